FILE: hw/rtl/sky_pkg.sv
// Shared types and constants for the skyline sweep maximum tracker.
// Holds beat structs, chain cell types, control codes and state encoding.
package sky_pkg;

  localparam int unsigned HeightW = 31;
  localparam int unsigned PosW    = 31;
  localparam int unsigned IdW     = 11;
  localparam int unsigned IdDepth = 1 << IdW;

  typedef enum logic {
    OP_START = 1'b0,
    OP_END   = 1'b1
  } op_e;

  typedef struct packed {
    logic               op;
    logic [PosW-1:0]    position;
    logic [IdW-1:0]     building_id;
    logic [HeightW-1:0] building_height;
  } in_beat_t;

  typedef struct packed {
    logic [PosW-1:0]    point_x;
    logic [HeightW-1:0] point_height;
  } out_beat_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INS,
    CMD_DEL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [HeightW-1:0] height;
  } chain_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [HeightW-1:0] height;
  } entry_t;

  typedef struct packed {
    logic               present;
    logic [HeightW-1:0] height;
  } id_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_INS,
    ST_EMIT
  } state_e;

endpackage

FILE: hw/rtl/skyline_sweep_max_tracker.sv
// Top level of the skyline sweep maximum tracker.
// Depends on sky_pkg, sky_cell and sky_id_table.
//
// Input beats carry one sorted event (start or end of a building) on a
// valid/ready channel. Output beats carry one skyline point whenever the
// highest active height changes. Heights live in a chain of cells kept
// sorted so the head always holds the maximum. An id table records which
// buildings are active and their heights. Ids of zero are dropped at once.
// An end of an active id, or a start of a new id, goes from ST_LOOK, which
// uses the table entry and commands the chain, to ST_EMIT, which loads
// the point into the output register if the maximum changed, then to
// ST_IDLE, where the next beat can be taken. A start of an active id
// removes the old height in ST_LOOK and inserts the new one in ST_INS
// before ST_EMIT. An end of an inactive id, or a start finding the chain
// full, returns from ST_LOOK to ST_IDLE. The chain takes one command per
// cycle. After reset all 2048 id table entries are swept clear, during
// which no input beat is taken. On a receiver stall the pending point is
// held and any event that changed the chain waits for it before finishing.
module skyline_sweep_max_tracker #(
  parameter int unsigned MAX_BUILDINGS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sky_pkg::in_beat_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sky_pkg::out_beat_t out_data_o
);
  import sky_pkg::*;

  state_e             state_q, state_d;
  logic [IdW-1:0]     clr_q, clr_d;
  in_beat_t           item_q;
  logic [HeightW-1:0] before_q, before_d;
  logic               out_valid_q, out_load;
  out_beat_t          out_q;

  chain_cmd_t         cmd;
  entry_t             cells [MAX_BUILDINGS];
  logic [HeightW-1:0] head_height;
  logic               chain_full;

  logic               tbl_we, tbl_re;
  logic [IdW-1:0]     tbl_waddr;
  id_entry_t          tbl_wdata, tbl_rdata;

  logic               in_accept;

  sky_id_table u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (in_data_i.building_id),
    .rdata_o (tbl_rdata)
  );

  for (genvar i = 0; i < MAX_BUILDINGS; i++) begin : g_cell
    entry_t left_e, right_e;
    if (i == 0) begin : g_head
      assign left_e = '{valid: 1'b1, height: '1};
    end else begin : g_left
      assign left_e = cells[i-1];
    end
    if (i == MAX_BUILDINGS - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_right
      assign right_e = cells[i+1];
    end
    sky_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_e),
      .right_i (right_e),
      .entry_o (cells[i])
    );
  end

  assign head_height = cells[0].valid ? cells[0].height : '0;
  assign chain_full  = cells[MAX_BUILDINGS-1].valid;
  assign in_accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    before_d   = before_q;
    cmd        = '{kind: CMD_NONE, height: '0};
    tbl_we     = 1'b0;
    tbl_waddr  = item_q.building_id;
    tbl_wdata  = '0;
    tbl_re     = 1'b0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        tbl_re     = in_valid_i;
        if (in_valid_i && (in_data_i.building_id != '0)) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        before_d = head_height;
        if (item_q.op == OP_START) begin
          if (tbl_rdata.present) begin
            cmd       = '{kind: CMD_DEL, height: tbl_rdata.height};
            tbl_we    = 1'b1;
            tbl_wdata = '{present: 1'b1, height: item_q.building_height};
            state_d   = ST_INS;
          end else if (chain_full) begin
            state_d = ST_IDLE;
          end else begin
            cmd       = '{kind: CMD_INS, height: item_q.building_height};
            tbl_we    = 1'b1;
            tbl_wdata = '{present: 1'b1, height: item_q.building_height};
            state_d   = ST_EMIT;
          end
        end else begin
          if (tbl_rdata.present) begin
            cmd     = '{kind: CMD_DEL, height: tbl_rdata.height};
            tbl_we  = 1'b1;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_INS: begin
        cmd     = '{kind: CMD_INS, height: item_q.building_height};
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = (head_height != before_q);
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    before_q <= before_d;
    if (out_load) begin
      out_q <= '{point_x: item_q.position, point_height: head_height};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/sky_cell.sv
// One cell of the sorted height chain, largest height nearest the head.
// Depends on sky_pkg for the command and entry types.
module sky_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sky_pkg::chain_cmd_t cmd_i,
  input  sky_pkg::entry_t     left_i,
  input  sky_pkg::entry_t     right_i,
  output sky_pkg::entry_t     entry_o
);
  import sky_pkg::*;

  entry_t entry_q, entry_d;
  logic   keep_ins, left_ge, at_or_below;

  assign keep_ins    = entry_q.valid && (entry_q.height >= cmd_i.height);
  assign left_ge     = left_i.valid && (left_i.height >= cmd_i.height);
  assign at_or_below = entry_q.valid && (entry_q.height <= cmd_i.height);

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.kind)
      CMD_INS: begin
        if (keep_ins) begin
          entry_d = entry_q;
        end else if (left_ge) begin
          entry_d = '{valid: 1'b1, height: cmd_i.height};
        end else begin
          entry_d = left_i;
        end
      end
      CMD_DEL: begin
        if (at_or_below) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: hw/rtl/sky_id_table.sv
// Table indexed by building id holding presence and the stored height.
// Depends on sky_pkg; one write port and one registered read port.
module sky_id_table (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [sky_pkg::IdW-1:0]     waddr_i,
  input  sky_pkg::id_entry_t          wdata_i,
  input  logic                        re_i,
  input  logic [sky_pkg::IdW-1:0]     raddr_i,
  output sky_pkg::id_entry_t          rdata_o
);
  import sky_pkg::*;

  id_entry_t mem_q [IdDepth];
  id_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sky_checker.sv
// Port-level checks for the skyline sweep maximum tracker, bound to the top.
// Depends on sky_pkg for the beat types.
module sky_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sky_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sky_pkg::out_beat_t out_data_o
);
  import sky_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("Output beat changed while stalled.");

  a_busy_after_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.building_id != '0) |=> !in_ready_o)
    else $error("Input taken again while an event is in progress.");

  a_zero_id_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.building_id == '0) |=> in_ready_o)
    else $error("A ground id event occupied the block.");

  a_no_fast_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_acc))
    else $error("Point produced one cycle after an event beat.");

endmodule

bind skyline_sweep_max_tracker sky_checker u_sky_checker (.*);
